// ===== rtl/core/tga_pkg.sv =====
// shared types, constants and register codes of the tga pixel stream decoder
package tga_pkg;

  // width of the remaining-pixel counter
  localparam int COUNT_WIDTH = 24;

  localparam int ADDR_WIDTH = 4;
  localparam int DATA_WIDTH = 32;
  localparam int PCOUNT_WIDTH = 24;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_RLE_MODE     = 2'd0;
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd1;
  localparam logic [1:0] REG_PIXEL_COUNT  = 2'd2;

  // pixel formats; the fourth code decodes as 32-bit
  localparam logic [1:0] FMT_RGB555 = 2'd0;
  localparam logic [1:0] FMT_BGR24  = 2'd1;
  localparam logic [1:0] FMT_BGRA32 = 2'd2;

  // reset values of the registers
  localparam logic                    RLE_RESET    = 1'b0;
  localparam logic [1:0]              FORMAT_RESET = FMT_BGR24;
  localparam logic [PCOUNT_WIDTH-1:0] PCOUNT_RESET = PCOUNT_WIDTH'(1);

  // packet header coding
  localparam logic [7:0] RUN_THRESHOLD = 8'd128;
  localparam logic [7:0] RUN_BIAS      = 8'd127;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

  typedef struct packed {
    logic                    rle_mode;
    logic [1:0]              pixel_format;
    logic [PCOUNT_WIDTH-1:0] pixel_count;
  } cfg_t;

  typedef struct packed {
    logic                    restart;
    logic [PCOUNT_WIDTH-1:0] count;
  } restart_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

endpackage

// ===== rtl/core/tga_cfg.sv =====
// configuration register bank with apb-style access
module tga_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tga_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [tga_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [tga_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                            pready,
  output tga_pkg::cfg_t                   cfg,
  output tga_pkg::restart_t               restart
);

  logic       wr;
  logic [1:0] idx;
  logic       known;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    unique case (idx) inside
      tga_pkg::REG_RLE_MODE,
      tga_pkg::REG_PIXEL_FORMAT,
      tga_pkg::REG_PIXEL_COUNT: known = 1'b1;
      default:                  known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rle_mode     <= tga_pkg::RLE_RESET;
      cfg.pixel_format <= tga_pkg::FORMAT_RESET;
      cfg.pixel_count  <= tga_pkg::PCOUNT_RESET;
    end else if (wr) begin
      unique case (idx)
        tga_pkg::REG_RLE_MODE:     cfg.rle_mode     <= pwdata[0];
        tga_pkg::REG_PIXEL_FORMAT: cfg.pixel_format <= pwdata[1:0];
        tga_pkg::REG_PIXEL_COUNT:  cfg.pixel_count  <= pwdata[tga_pkg::PCOUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // restart takes the count being written so the stream restarts at the same edge
  always_comb begin
    restart.restart = wr & known;
    restart.count   = (idx == tga_pkg::REG_PIXEL_COUNT)
                      ? pwdata[tga_pkg::PCOUNT_WIDTH-1:0] : cfg.pixel_count;
  end

  always_comb begin
    unique case (idx)
      tga_pkg::REG_RLE_MODE:
        prdata = {{(tga_pkg::DATA_WIDTH-1){1'b0}}, cfg.rle_mode};
      tga_pkg::REG_PIXEL_FORMAT:
        prdata = {{(tga_pkg::DATA_WIDTH-2){1'b0}}, cfg.pixel_format};
      tga_pkg::REG_PIXEL_COUNT:
        prdata = {{(tga_pkg::DATA_WIDTH-tga_pkg::PCOUNT_WIDTH){1'b0}}, cfg.pixel_count};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/tga_decode.sv =====
// colour decode of one complete pixel from its stored bytes and last byte
module tga_decode (
  input  logic [1:0]    pixel_format,
  input  logic [23:0]   pixel_bytes,
  input  logic [7:0]    last_byte,
  output tga_pkg::rgba_t colour
);

  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;

  assign b0 = pixel_bytes[7:0];
  assign b1 = pixel_bytes[15:8];
  assign b2 = pixel_bytes[23:16];

  always_comb begin
    case (pixel_format)
      tga_pkg::FMT_RGB555: begin
        // little-endian 5-5-5, top bit ignored
        colour.blue  = {b0[4:0], 3'b000};
        colour.green = {last_byte[1:0], b0[7:5], 3'b000};
        colour.red   = {last_byte[6:2], 3'b000};
        colour.alpha = tga_pkg::ALPHA_OPAQUE;
      end
      tga_pkg::FMT_BGR24: begin
        colour.blue  = b0;
        colour.green = b1;
        colour.red   = last_byte;
        colour.alpha = tga_pkg::ALPHA_OPAQUE;
      end
      default: begin
        colour.blue  = b0;
        colour.green = b1;
        colour.red   = b2;
        colour.alpha = last_byte;
      end
    endcase
  end

endmodule

// ===== rtl/core/tga_ctrl.sv =====
// packet and pixel sequencing with the result register
module tga_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  tga_pkg::cfg_t     cfg,
  input  tga_pkg::restart_t restart,
  input  logic              data_valid,
  input  logic [7:0]        data_byte,
  output logic              data_stall,
  output logic              pixel_valid,
  input  logic              pixel_stall,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic [7:0]        alpha,
  output logic [7:0]        repeat_res,
  output logic              last_pixel,
  output logic              overrun
);

  localparam int CW = tga_pkg::COUNT_WIDTH;

  logic          expect_header, expect_header_next;
  logic          run_packet, run_packet_next;
  logic [7:0]    packet_left, packet_left_next;
  logic [1:0]    byte_phase, byte_phase_next;
  logic [23:0]   pixel_bytes, pixel_bytes_next;
  logic [CW-1:0] pixels_left, pixels_left_next;
  logic          image_done, image_done_next;

  logic          header_cycle;
  logic [1:0]    last_phase;
  logic          emit_pos;
  logic          accept;
  logic          emit;
  logic          over;
  logic [7:0]    rpt;
  logic [CW-1:0] pixels_after;
  logic [23:0]   shifted;
  tga_pkg::rgba_t colour;

  tga_decode u_decode (
    .pixel_format (cfg.pixel_format),
    .pixel_bytes  (pixel_bytes),
    .last_byte    (data_byte),
    .colour       (colour)
  );

  always_comb begin
    case (cfg.pixel_format)
      tga_pkg::FMT_RGB555: last_phase = 2'd1;
      tga_pkg::FMT_BGR24:  last_phase = 2'd2;
      default:             last_phase = 2'd3;
    endcase
  end

  assign header_cycle = cfg.rle_mode & expect_header;
  assign emit_pos     = ~image_done & ~header_cycle & (byte_phase >= last_phase);
  // only a transaction that yields a pixel waits for the result register
  assign data_stall   = pixel_valid & pixel_stall & emit_pos;
  assign accept       = data_valid & ~data_stall;
  assign emit         = accept & emit_pos;

  // repeat count: one, or in a run packet its run length, cut to what is left of the image
  always_comb begin
    over = 1'b0;
    rpt  = 8'd1;
    if (cfg.rle_mode && run_packet) begin
      if (CW'(packet_left) > pixels_left) begin
        over = 1'b1;
        rpt  = pixels_left[7:0];
      end else begin
        rpt  = packet_left;
      end
    end
  end

  assign pixels_after = pixels_left - CW'(rpt);

  always_comb begin
    case (byte_phase)
      2'd0:    shifted = {16'd0, data_byte};
      2'd1:    shifted = {8'd0, data_byte, 8'd0};
      default: shifted = {data_byte, 16'd0};
    endcase
  end

  always_comb begin
    expect_header_next = expect_header;
    run_packet_next    = run_packet;
    packet_left_next   = packet_left;
    byte_phase_next    = byte_phase;
    pixel_bytes_next   = pixel_bytes;
    pixels_left_next   = pixels_left;
    image_done_next    = image_done;
    if (restart.restart) begin
      expect_header_next = 1'b1;
      run_packet_next    = 1'b0;
      packet_left_next   = '0;
      byte_phase_next    = '0;
      pixel_bytes_next   = '0;
      pixels_left_next   = CW'(restart.count);
      image_done_next    = (CW'(restart.count) == '0);
    end else if (accept && !image_done) begin
      if (header_cycle) begin
        if (data_byte < tga_pkg::RUN_THRESHOLD) begin
          run_packet_next  = 1'b0;
          packet_left_next = data_byte + 8'd1;
        end else begin
          run_packet_next  = 1'b1;
          packet_left_next = data_byte - tga_pkg::RUN_BIAS;
        end
        expect_header_next = 1'b0;
        byte_phase_next    = '0;
        pixel_bytes_next   = '0;
      end else if (!emit_pos) begin
        pixel_bytes_next = pixel_bytes | shifted;
        byte_phase_next  = byte_phase + 2'd1;
      end else begin
        byte_phase_next  = '0;
        pixel_bytes_next = '0;
        if (cfg.rle_mode) begin
          if (run_packet) begin
            packet_left_next   = '0;
            expect_header_next = 1'b1;
          end else begin
            packet_left_next   = packet_left - 8'd1;
            expect_header_next = (packet_left == 8'd1);
          end
        end
        pixels_left_next = pixels_after;
        image_done_next  = (pixels_after == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      packet_left   <= '0;
      byte_phase    <= '0;
      pixel_bytes   <= '0;
      pixels_left   <= CW'(tga_pkg::PCOUNT_RESET);
      image_done    <= 1'b0;
      pixel_valid   <= 1'b0;
    end else begin
      expect_header <= expect_header_next;
      run_packet    <= run_packet_next;
      packet_left   <= packet_left_next;
      byte_phase    <= byte_phase_next;
      pixel_bytes   <= pixel_bytes_next;
      pixels_left   <= pixels_left_next;
      image_done    <= image_done_next;
      if (emit)              pixel_valid <= 1'b1;
      else if (!pixel_stall) pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      red        <= colour.red;
      green      <= colour.green;
      blue       <= colour.blue;
      alpha      <= colour.alpha;
      repeat_res <= rpt;
      last_pixel <= (pixels_after == '0);
      overrun    <= over;
    end
  end

  a_done_means_empty: assert property (@(posedge clk) disable iff (rst)
    image_done |-> (pixels_left == '0))
    else $error("image marked done with pixels still left");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit |=> (pixel_valid && repeat_res != 8'd0 && repeat_res <= tga_pkg::RUN_THRESHOLD))
    else $error("pixel transaction not loaded or repeat out of range");

  a_overrun_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && over) |=> (last_pixel && image_done))
    else $error("cut run did not complete the image");

endmodule

// ===== rtl/core/tga_pixel_stream_decoder.sv =====
// top level of the tga pixel stream decoder
//
// data channel: one pixel-data byte per transaction (data_valid, data_stall,
// data_byte). pixel channel: one decoded colour per transaction with its
// repeat count, last_pixel and overrun flags (pixel_valid, pixel_stall).
// configuration: apb-style port, rle_mode at 0x0, pixel_format at 0x4,
// pixel_count at 0x8; a write to any of these restarts the stream at that edge
//
// latency: the byte that completes a pixel is decoded in the cycle it is
// accepted and the pixel appears on the result register the next cycle
// throughput: one byte per cycle while data_stall is low, set by the single
// state update of the packet and pixel counters; header bytes and partial
// pixel bytes give no transaction on the pixel channel
//
// reset: registers return to uncompressed 24-bit, one pixel; the stream
// waits for its first byte with no pixel pending
// stall: while the result register holds a pixel and the receiver stalls,
// bytes that would complete another pixel are stalled; bytes that only
// advance the packet or pixel state are still taken
module tga_pixel_stream_decoder (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tga_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [tga_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [tga_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                            pready,
  // byte input
  input  logic                            data_valid,
  output logic                            data_stall,
  input  logic [7:0]                      data_byte,
  // pixel output
  output logic                            pixel_valid,
  input  logic                            pixel_stall,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic [7:0]                      alpha,
  output logic [7:0]                      repeat_res,
  output logic                            last_pixel,
  output logic                            overrun
);

  tga_pkg::cfg_t     cfg;
  tga_pkg::restart_t restart;

  // register bank, also flags the restart on a write
  tga_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  // packet parsing, pixel assembly and the result register
  tga_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .restart     (restart),
    .data_valid  (data_valid),
    .data_byte   (data_byte),
    .data_stall  (data_stall),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .repeat_res  (repeat_res),
    .last_pixel  (last_pixel),
    .overrun     (overrun)
  );

endmodule
